// File: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is off while reset is held.
`define SSEL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent check that also runs through reset.
`define SSEL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ssel_pkg.sv
// Types and constants shared by the sequence step selector.
`timescale 1ns / 1ps
package ssel_pkg;

  localparam int LEVEL_W    = 10;
  localparam int MARGIN_W   = 8;
  localparam int STEP_W     = 4;
  localparam int LINES_W    = 4;
  localparam int LENGTH_W   = 4;
  localparam int PATTERN_W  = 60;
  localparam int CMP_W      = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 60;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_UP     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_DOWN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_MARGIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEQ_LENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN      = 3'd4;

  // Register values after reset
  localparam logic [LEVEL_W-1:0]   RST_LEVEL_UP     = 10'd219;
  localparam logic [LEVEL_W-1:0]   RST_LEVEL_DOWN   = 10'd156;
  localparam logic [MARGIN_W-1:0]  RST_LEVEL_MARGIN = 8'd6;
  localparam logic [LENGTH_W-1:0]  RST_SEQ_LENGTH   = 4'd5;
  localparam logic [PATTERN_W-1:0] RST_PATTERN      = 60'd541200;

  typedef struct packed {
    logic [LEVEL_W-1:0]   level_up;
    logic [LEVEL_W-1:0]   level_down;
    logic [MARGIN_W-1:0]  level_margin;
    logic [LENGTH_W-1:0]  seq_length;
    logic [PATTERN_W-1:0] pattern_words;
  } cfg_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] filtered_level;
    logic               signal_lost;
  } tick_t;

  typedef struct packed {
    logic [LINES_W-1:0] output_bits;
    logic [STEP_W-1:0]  step_index;
  } result_t;

endpackage

// File: rtl/ssel_cfg.sv
// Configuration register file of the sequence step selector.
`timescale 1ns / 1ps
module ssel_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [ssel_pkg::CFG_IDX_W-1:0]    wr_index,
  input  logic [ssel_pkg::CFG_DATA_W-1:0]   wr_data,
  output ssel_pkg::cfg_t                    cfg
);

  ssel_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.level_up      <= ssel_pkg::RST_LEVEL_UP;
      cfg_r.level_down    <= ssel_pkg::RST_LEVEL_DOWN;
      cfg_r.level_margin  <= ssel_pkg::RST_LEVEL_MARGIN;
      cfg_r.seq_length    <= ssel_pkg::RST_SEQ_LENGTH;
      cfg_r.pattern_words <= ssel_pkg::RST_PATTERN;
    end else if (wr_en) begin
      unique case (wr_index)
        ssel_pkg::REG_LEVEL_UP:     cfg_r.level_up     <= wr_data[ssel_pkg::LEVEL_W-1:0];
        ssel_pkg::REG_LEVEL_DOWN:   cfg_r.level_down   <= wr_data[ssel_pkg::LEVEL_W-1:0];
        ssel_pkg::REG_LEVEL_MARGIN: cfg_r.level_margin <= wr_data[ssel_pkg::MARGIN_W-1:0];
        ssel_pkg::REG_SEQ_LENGTH:   cfg_r.seq_length   <= wr_data[ssel_pkg::LENGTH_W-1:0];
        ssel_pkg::REG_PATTERN:      cfg_r.pattern_words <= wr_data[ssel_pkg::PATTERN_W-1:0];
        default: begin
          // drop writes to unmapped indexes
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: rtl/ssel_step.sv
// Arm flag, step index and pattern lookup of the sequence step selector.
`timescale 1ns / 1ps
module ssel_step #(
  parameter int MAX_STEPS    = 15,
  parameter int OUTPUT_LINES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  ssel_pkg::tick_t   tick,
  input  ssel_pkg::cfg_t    cfg,
  output ssel_pkg::result_t res
);

  localparam logic [ssel_pkg::STEP_W-1:0]  MAX_IDX   = ssel_pkg::STEP_W'(MAX_STEPS);
  localparam logic [ssel_pkg::LINES_W-1:0] LINE_MASK =
    ssel_pkg::LINES_W'((1 << OUTPUT_LINES) - 1);
  localparam int CW = ssel_pkg::CMP_W;

  logic [ssel_pkg::STEP_W-1:0] step_r, step_nxt;
  logic                        armed_r, armed_nxt;

  logic signed [CW-1:0] lvl_s, up_s, down_s, m_s;
  logic signed [CW-1:0] win_hi, win_lo, fwd_thr, back_thr;
  logic                 neutral, armed_pre, go_fwd, go_back;
  logic [ssel_pkg::LENGTH_W-1:0] len;
  logic [ssel_pkg::STEP_W:0]     step_inc;
  logic [ssel_pkg::STEP_W-1:0]   fwd_step, back_step;
  logic [ssel_pkg::PATTERN_W-1:0] pat_shift;

  always_comb begin
    lvl_s  = signed'({{(CW-ssel_pkg::LEVEL_W){1'b0}}, tick.filtered_level});
    up_s   = signed'({{(CW-ssel_pkg::LEVEL_W){1'b0}}, cfg.level_up});
    down_s = signed'({{(CW-ssel_pkg::LEVEL_W){1'b0}}, cfg.level_down});
    m_s    = signed'({{(CW-ssel_pkg::MARGIN_W){1'b0}}, cfg.level_margin});

    win_hi   = up_s - m_s;
    win_lo   = down_s + m_s;
    fwd_thr  = up_s + m_s;
    back_thr = down_s - m_s;

    neutral   = (lvl_s < win_hi) && (lvl_s > win_lo);
    armed_pre = (armed_r && !tick.signal_lost) || neutral;
    go_fwd    = armed_pre && (lvl_s > fwd_thr);
    go_back   = armed_pre && !go_fwd && (lvl_s < back_thr);
    armed_nxt = armed_pre && !go_fwd && !go_back;

    len = (cfg.seq_length > MAX_IDX) ? MAX_IDX : cfg.seq_length;

    // forward wraps to 0 at the length, also from an index left above it
    step_inc = {1'b0, step_r} + 5'd1;
    fwd_step = (step_inc >= {1'b0, len}) ? '0 : step_inc[ssel_pkg::STEP_W-1:0];

    if (len == '0) begin
      back_step = '0;
    end else if (step_r == '0) begin
      back_step = len - 4'd1;
    end else begin
      back_step = step_r - 4'd1;
    end

    if (go_fwd) begin
      step_nxt = fwd_step;
    end else if (go_back) begin
      step_nxt = back_step;
    end else begin
      step_nxt = step_r;
    end

    pat_shift = cfg.pattern_words >> {step_nxt, 2'b00};
    res.step_index = step_nxt;
    if (step_nxt >= MAX_IDX) begin
      res.output_bits = '0;
    end else begin
      res.output_bits = pat_shift[ssel_pkg::LINES_W-1:0] & LINE_MASK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      armed_r <= 1'b0;
    end else if (advance) begin
      step_r  <= step_nxt;
      armed_r <= armed_nxt;
    end
  end

endmodule

// File: rtl/sequence_step_selector_top.sv
// Sequence step selector: moves an index through a short pattern sequence
// from filtered servo channel levels.
//
// Input channel (in_): one transfer per recalculation tick carries the
// filtered level in in_tdata and the signal-lost flag in in_tuser.
// Result channel (out_): one transfer per input tick, carrying the step
// index after the update and the output pattern of that step.
// Configuration channel (cfg_): writes one register per transfer; it is
// always ready. Write only while no tick is in flight.
//
// A tick accepted on in_ is held in the input register, then passes the
// single compare and index-update stage into the result register, which
// drives out_. Throughput: one tick per cycle while out_tready stays
// high.
// Reset (rst_n low, synchronous): the index and arm flag clear, the
// registers return to their defaults, both stages empty.
// Receiver stall: the result register holds its transfer; one more tick
// can sit in the input register, after which in_tready drops.
`timescale 1ns / 1ps
module sequence_step_selector_top #(
  parameter int MAX_STEPS    = 15,
  parameter int OUTPUT_LINES = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input ticks
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ssel_pkg::IN_DATA_W-1:0]      in_tdata,   // [9:0] filtered_level
  input  logic                                in_tuser,   // [0] signal_lost
  // results
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ssel_pkg::OUT_DATA_W-1:0]     out_tdata,  // [3:0] step_index, [7:4] output_bits
  // configuration writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ssel_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssel_pkg::CFG_DATA_W-1:0]     cfg_data
);

  ssel_pkg::cfg_t    cfg;
  ssel_pkg::tick_t   tick_r;
  ssel_pkg::result_t res_comb;
  ssel_pkg::result_t res_r;
  logic              tick_valid_r;
  logic              out_valid_r;
  logic              advance;

  // Configuration writes are always accepted.
  assign cfg_ready = 1'b1;

  ssel_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Advance the held tick into the result register when that slot is free
  // or being emptied in this cycle.
  assign advance   = tick_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !tick_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_valid_r <= 1'b0;
    end else if (in_tready) begin
      tick_valid_r <= in_tvalid;
    end
  end

  // Capture the payload on every input transfer.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      tick_r.filtered_level <= in_tdata[ssel_pkg::LEVEL_W-1:0];
      tick_r.signal_lost    <= in_tuser;
    end
  end

  ssel_step #(
    .MAX_STEPS    (MAX_STEPS),
    .OUTPUT_LINES (OUTPUT_LINES)
  ) u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .tick    (tick_r),
    .cfg     (cfg),
    .res     (res_comb)
  );

  // Result register: fills on advance, empties on an output transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_comb;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_r.output_bits, res_r.step_index};

endmodule

// File: rtl/ssel_checker.sv
// Port-level checks of the sequence step selector and their binding.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ssel_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // a stalled result stays put
  `SSEL_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "result changed while stalled")

  // every new result traces back to an input transfer that passed through the input register
  `SSEL_ASSERT(a_no_phantom, clk, rst_n, $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2), "result without an input transfer")

  // the index never reaches the top code
  `SSEL_ASSERT(a_index_range, clk, rst_n, out_tvalid |-> out_tdata[3:0] != 4'hF, "step index out of range")

  // reset empties the result side
  `SSEL_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind sequence_step_selector_top ssel_checker u_ssel_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
